FILE: rtl/tpm_pkg.sv
// Shared constants and types for the text word pattern matcher.
package tpm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int PLEN_W          = 6;
    localparam int LEN_W           = 16;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int PAT_WORDS       = 4;
    localparam int CHARS_PER_WORD  = 8;

    localparam logic [7:0] CHAR_NL  = 8'd10;
    localparam logic [7:0] CHAR_SP  = 8'd32;
    localparam logic [7:0] CHAR_TAB = 8'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_3 = 3'd5;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    localparam logic MODE_LINE = 1'b0;
    localparam logic MODE_WORD = 1'b1;

    typedef struct packed {
        logic take;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic             item_kind;
        logic [LEN_W-1:0] item_number;
        logic [LEN_W-1:0] item_length;
    } result_t;

endpackage

FILE: rtl/tpm_if.sv
// Handshake channels for text input and match reports.
interface tpm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tpm_report_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [15:0] item_number;
    logic [15:0] item_length;

    modport source (output valid, output item_kind, output item_number,
                    output item_length, input ready);
    modport sink (input valid, input item_kind, input item_number,
                  input item_length, output ready);
endinterface

FILE: rtl/tpm_cell.sv
// One match cell: tracks whether the current word ends with one pattern prefix.
module tpm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tpm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         ch,
    input  logic [7:0]         pat_char,
    input  logic               last,
    input  logic               prev,
    output logic               eq,
    output logic               hit,
    output logic               match
);

    logic match_reg;
    logic match_next;

    assign eq  = (ch == pat_char);
    assign hit = last && prev && eq;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.take)
        begin
            match_next = prev && eq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

FILE: rtl/tpm_out_stage.sv
// Output register holding one report item until the receiver takes it.
module tpm_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tpm_pkg::result_t     d,
    output logic                 free,
    tpm_report_if.source         report
);

    logic             valid_reg;
    logic             valid_next;
    tpm_pkg::result_t data_reg;

    assign free = !valid_reg || report.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

    assign report.valid       = valid_reg;
    assign report.item_kind   = data_reg.item_kind;
    assign report.item_number = data_reg.item_number;
    assign report.item_length = data_reg.item_length;

endmodule

FILE: rtl/text_word_pattern_matcher.sv
// Top level: streaming word and line pattern matcher built on a chain of match cells.
// Usage:
//   text   : one byte per item (text_byte, end_of_text) with valid/ready.
//            Space and tab separate words, newline or end_of_text ends a line.
//   report : zero or one item per input item: item_kind (line or word),
//            item_number (running line or word count) and item_length.
//   cfg    : cfg_we/cfg_index/cfg_data write mode, pattern_length and the
//            four pattern character words; write only while the block is idle.
// Throughput: one text item per cycle while not stalled. Every match cell updates
//   in the same cycle from its left neighbor, so the cell chain sets no limit on rate.
// Reports: a report is registered and appears on the report channel in the cycle
//   after the text item that closes the word or line is accepted.
// Stall: the output register holds a report until it is taken; text is
//   accepted while that register is empty or being drained this cycle.
// Reset: all cells, counts and the stop flag clear, mode is line mode and
//   pattern_length is 1. An empty line halts all reports until next reset.
module text_word_pattern_matcher #(
    parameter int PATTERN_MAX = tpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpm_pkg::CFG_W-1:0]     cfg_data,
    tpm_text_if.sink                      text,
    tpm_report_if.source                  report
);

    localparam int IW = $clog2(PATTERN_MAX + 1);
    localparam int LW = tpm_pkg::LEN_W;
    localparam int PW = tpm_pkg::PLEN_W;

    // configuration
    logic                                               mode_reg;
    logic [PW-1:0]                                      plen_reg;
    logic [tpm_pkg::PAT_WORDS-1:0][tpm_pkg::CFG_W-1:0]  pat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tpm_pkg::MODE_LINE;
            plen_reg <= PW'(1);
            pat_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpm_pkg::CFG_MODE:    mode_reg   <= cfg_data[0];
                tpm_pkg::CFG_PLEN:    plen_reg   <= cfg_data[PW-1:0];
                tpm_pkg::CFG_CHARS_0: pat_reg[0] <= cfg_data;
                tpm_pkg::CFG_CHARS_1: pat_reg[1] <= cfg_data;
                tpm_pkg::CFG_CHARS_2: pat_reg[2] <= cfg_data;
                tpm_pkg::CFG_CHARS_3: pat_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective pattern length, clamped to 1..PATTERN_MAX
    logic [PW-1:0] plen;
    always_comb
    begin
        plen = plen_reg;
        if (plen_reg == '0)
        begin
            plen = PW'(1);
        end
        else if (plen_reg > PW'(PATTERN_MAX))
        begin
            plen = PW'(PATTERN_MAX);
        end
    end

    // state
    logic [IW-1:0] sidx_reg, sidx_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    logic [LW-1:0] llen_reg, llen_next;
    logic          lhit_reg, lhit_next;
    logic [LW-1:0] lcnt_reg, lcnt_next;
    logic [LW-1:0] wcnt_reg, wcnt_next;
    logic          stopped_reg, stopped_next;

    logic               free;
    logic               acc;
    logic               load;
    tpm_pkg::result_t   res;
    tpm_pkg::cell_ctrl_t ctrl;

    logic [PATTERN_MAX-1:0] cell_eq;
    logic [PATTERN_MAX-1:0] cell_hit;
    logic [PATTERN_MAX:0]   chain;

    assign text.ready = free;
    assign acc        = text.valid && free;

    assign chain[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            tpm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .ch       (text.text_byte),
                .pat_char (pat_reg[k / tpm_pkg::CHARS_PER_WORD]
                                  [(k % tpm_pkg::CHARS_PER_WORD) * 8 +: 8]),
                .last     (plen == PW'(k + 1)),
                .prev     (chain[k]),
                .eq       (cell_eq[k]),
                .hit      (cell_hit[k]),
                .match    (chain[k + 1])
            );
        end
    endgenerate

    // pattern character at the subsequence position matches this byte
    logic eq_sel;
    always_comb
    begin
        eq_sel = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            eq_sel = eq_sel | (cell_eq[i] & (sidx_reg == IW'(i)));
        end
    end

    logic          is_eot;
    logic          is_nl;
    logic          is_sep;
    logic [LW-1:0] plen_w;
    logic [LW-1:0] wcnt_inc;
    logic [LW-1:0] lcnt_inc;

    assign is_eot   = text.end_of_text;
    assign is_nl    = !is_eot && (text.text_byte == tpm_pkg::CHAR_NL);
    assign is_sep   = !is_eot && ((text.text_byte == tpm_pkg::CHAR_SP) ||
                                  (text.text_byte == tpm_pkg::CHAR_TAB));
    assign plen_w   = LW'(plen);
    assign wcnt_inc = wcnt_reg + LW'(1);
    assign lcnt_inc = lcnt_reg + LW'(1);

    always_comb
    begin
        sidx_next    = sidx_reg;
        wlen_next    = wlen_reg;
        llen_next    = llen_reg;
        lhit_next    = lhit_reg;
        lcnt_next    = lcnt_reg;
        wcnt_next    = wcnt_reg;
        stopped_next = stopped_reg;
        ctrl         = '0;
        load         = 1'b0;
        res          = '0;

        if (acc && !stopped_reg)
        begin
            if (is_eot || is_nl || is_sep)
            begin
                // close the pending word
                ctrl.clear = 1'b1;
                if (wlen_reg != '0)
                begin
                    wcnt_next = wcnt_inc;
                    if ((mode_reg == tpm_pkg::MODE_WORD) && (PW'(sidx_reg) == plen) &&
                        ((wlen_reg == plen_w) || (wlen_reg == plen_w + LW'(1))))
                    begin
                        load            = 1'b1;
                        res.item_kind   = tpm_pkg::KIND_WORD;
                        res.item_number = wcnt_inc;
                        res.item_length = wlen_reg;
                    end
                end
                sidx_next = '0;
                wlen_next = '0;

                if (is_sep)
                begin
                    llen_next = (llen_reg == '1) ? llen_reg : llen_reg + LW'(1);
                end
                else if (is_nl && (llen_reg == '0))
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    // close the line
                    if (llen_reg != '0)
                    begin
                        lcnt_next = lcnt_inc;
                        if ((mode_reg == tpm_pkg::MODE_LINE) && lhit_reg)
                        begin
                            load            = 1'b1;
                            res.item_kind   = tpm_pkg::KIND_LINE;
                            res.item_number = lcnt_inc;
                            res.item_length = llen_reg;
                        end
                    end
                    llen_next = '0;
                    lhit_next = 1'b0;
                end
            end
            else
            begin
                ctrl.take = 1'b1;
                if (|cell_hit)
                begin
                    lhit_next = 1'b1;
                end
                if ((PW'(sidx_reg) < plen) && eq_sel)
                begin
                    sidx_next = sidx_reg + IW'(1);
                end
                wlen_next = (wlen_reg == '1) ? wlen_reg : wlen_reg + LW'(1);
                llen_next = (llen_reg == '1) ? llen_reg : llen_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg    <= '0;
            wlen_reg    <= '0;
            llen_reg    <= '0;
            lhit_reg    <= 1'b0;
            lcnt_reg    <= '0;
            wcnt_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            sidx_reg    <= sidx_next;
            wlen_reg    <= wlen_next;
            llen_reg    <= llen_next;
            lhit_reg    <= lhit_next;
            lcnt_reg    <= lcnt_next;
            wcnt_reg    <= wcnt_next;
            stopped_reg <= stopped_next;
        end
    end

    tpm_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .d      (res),
        .free   (free),
        .report (report)
    );

endmodule

FILE: bench/tpm_report_checker.sv
// Scoreboard for the text word pattern matcher: predicts reports from text items and checks them.
`timescale 1ns / 1ps

module tpm_report_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpm_pkg::CFG_W-1:0]     cfg_data,
    tpm_text_if                           text,
    tpm_report_if                         report,
    output int                            fail_count,
    output int                            pending_count
);

    localparam int CELLS = tpm_pkg::PATTERN_MAX_DEF;

    typedef logic [tpm_pkg::PLEN_W-1:0] plen_t;
    typedef logic [tpm_pkg::LEN_W-1:0]  len_t;

    // register copies
    logic                      mode_q;
    plen_t                     plen_q;
    logic [tpm_pkg::CFG_W-1:0] pat_words [tpm_pkg::PAT_WORDS];

    // matcher state
    logic [CELLS-1:0]  cells;
    int                seq_idx;
    len_t              word_len;
    len_t              line_len;
    len_t              line_cnt;
    len_t              word_cnt;
    logic              line_hit;
    logic              halted;

    tpm_pkg::result_t  expected_reports [$];
    int                errors;

    function automatic int pattern_span();
        int p;
        p = int'(plen_q);
        if (p < 1) p = 1;
        if (p > CELLS) p = CELLS;
        return p;
    endfunction

    function automatic logic [7:0] pat_char(input int k);
        return pat_words[k / tpm_pkg::CHARS_PER_WORD]
                        [(k % tpm_pkg::CHARS_PER_WORD) * 8 +: 8];
    endfunction

    function automatic len_t bump_sat(input len_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic close_word();
        int               p;
        tpm_pkg::result_t r;
        p = pattern_span();
        if (word_len != 0)
        begin
            word_cnt = word_cnt + 1'b1;
            if (mode_q == tpm_pkg::MODE_WORD && seq_idx == p &&
                (word_len == p || word_len == p + 1))
            begin
                r.item_kind   = tpm_pkg::KIND_WORD;
                r.item_number = word_cnt;
                r.item_length = word_len;
                expected_reports.push_back(r);
            end
        end
        cells    = '0;
        seq_idx  = 0;
        word_len = '0;
    endtask

    task automatic close_line();
        tpm_pkg::result_t r;
        if (line_len != 0)
        begin
            line_cnt = line_cnt + 1'b1;
            if (mode_q == tpm_pkg::MODE_LINE && line_hit)
            begin
                r.item_kind   = tpm_pkg::KIND_LINE;
                r.item_number = line_cnt;
                r.item_length = line_len;
                expected_reports.push_back(r);
            end
        end
        line_len = '0;
        line_hit = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c);
        int p;
        int k;
        p = pattern_span();
        // walk downward so each cell sees its neighbor's old value
        for (k = CELLS - 1; k >= 0; k--)
            cells[k] = ((k == 0) ? 1'b1 : cells[k-1]) && (c == pat_char(k));
        if (cells[p-1]) line_hit = 1'b1;
        if (seq_idx < p && c == pat_char(seq_idx)) seq_idx++;
        word_len = bump_sat(word_len);
        line_len = bump_sat(line_len);
    endtask

    task automatic absorb_text_item(input logic [7:0] c, input logic eot);
        if (halted) return;
        if (eot)
        begin
            close_word();
            close_line();
        end
        else if (c == tpm_pkg::CHAR_NL)
        begin
            close_word();
            if (line_len == 0) halted = 1'b1;
            else close_line();
        end
        else if (c == tpm_pkg::CHAR_SP || c == tpm_pkg::CHAR_TAB)
        begin
            close_word();
            line_len = bump_sat(line_len);
        end
        else
        begin
            take_char(c);
        end
    endtask

    task automatic note_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: report %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tpm_pkg::result_t want;
        int               k;
        if (!rst_n)
        begin
            mode_q   = tpm_pkg::MODE_LINE;
            plen_q   = plen_t'(1);
            for (k = 0; k < tpm_pkg::PAT_WORDS; k++) pat_words[k] = '0;
            cells    = '0;
            seq_idx  = 0;
            word_len = '0;
            line_len = '0;
            line_cnt = '0;
            word_cnt = '0;
            line_hit = 1'b0;
            halted   = 1'b0;
            errors   = 0;
            expected_reports.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected report kind %0d number %0d length %0d",
                             $time, report.item_kind, report.item_number, report.item_length);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    note_field("item_kind", want.item_kind, report.item_kind);
                    note_field("item_number", want.item_number, report.item_number);
                    note_field("item_length", want.item_length, report.item_length);
                end
            end
            if (text.valid && text.ready)
                absorb_text_item(text.text_byte, text.end_of_text);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tpm_pkg::CFG_MODE:    mode_q       = cfg_data[0];
                    tpm_pkg::CFG_PLEN:    plen_q       = cfg_data[tpm_pkg::PLEN_W-1:0];
                    tpm_pkg::CFG_CHARS_0: pat_words[0] = cfg_data;
                    tpm_pkg::CFG_CHARS_1: pat_words[1] = cfg_data;
                    tpm_pkg::CFG_CHARS_2: pat_words[2] = cfg_data;
                    tpm_pkg::CFG_CHARS_3: pat_words[3] = cfg_data;
                    default:              ;
                endcase
            end
            fail_count    <= errors;
            pending_count <= expected_reports.size();
        end
    end

endmodule

FILE: bench/tb_text_word_pattern_matcher.sv
// Testbench top for the text word pattern matcher: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_text_word_pattern_matcher;

    typedef logic [tpm_pkg::PLEN_W-1:0] plen_t;

    localparam logic [tpm_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [tpm_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam logic [tpm_pkg::CFG_IDX_W-1:0] CHAR_REGS [tpm_pkg::PAT_WORDS] =
        '{tpm_pkg::CFG_CHARS_0, tpm_pkg::CFG_CHARS_1,
          tpm_pkg::CFG_CHARS_2, tpm_pkg::CFG_CHARS_3};

    localparam int RANDOM_ITEMS   = 800;
    localparam int STALL_LIMIT    = 3000;

    typedef enum int {
        SHAPE_EXACT, SHAPE_INSERT, SHAPE_WRAP, SHAPE_DROP,
        SHAPE_SWAP, SHAPE_INSERT2, SHAPE_SCRAMBLE
    } word_shape_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tpm_pkg::CFG_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending_count;

    logic [7:0]           pat_bytes [tpm_pkg::PATTERN_MAX_DEF];
    int                   pat_len;
    logic                 line_open;
    logic                 no_idle;
    int                   items_sent;
    int                   idle_cycles = 0;

    tpm_text_if   text_ch ();
    tpm_report_if report_ch ();

    text_word_pattern_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .report    (report_ch)
    );

    tpm_report_checker report_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .text          (text_ch),
        .report        (report_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else if ((text_ch.valid && text_ch.ready) || (report_ch.valid && report_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_text_word_pattern_matcher: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic is_gap_byte(input logic [7:0] b);
        return b == tpm_pkg::CHAR_SP || b == tpm_pkg::CHAR_TAB || b == tpm_pkg::CHAR_NL;
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) b = pat_bytes[$urandom_range(0, pat_len - 1)];
        else b = 8'($urandom_range(0, 255));
        while (is_gap_byte(b)) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic int clamp_len(input plen_t plen_raw);
        if (plen_raw == 0) return 1;
        if (plen_raw > tpm_pkg::PATTERN_MAX_DEF) return tpm_pkg::PATTERN_MAX_DEF;
        return int'(plen_raw);
    endfunction

    task automatic send_text(input logic [7:0] b, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        items_sent++;
        line_open = !(eot || b == tpm_pkg::CHAR_NL);
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
    endtask

    // hold the sender until every predicted report has been taken
    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpm_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_matcher(input logic m, input plen_t plen_raw);
        logic [tpm_pkg::CFG_W-1:0] d;
        int                        r;
        int                        j;
        wait_idle();
        d = {$urandom, $urandom};
        d[0] = m;
        write_reg(tpm_pkg::CFG_MODE, d);
        d = {$urandom, $urandom};
        d[tpm_pkg::PLEN_W-1:0] = plen_raw;
        write_reg(tpm_pkg::CFG_PLEN, d);
        for (r = 0; r < tpm_pkg::PAT_WORDS; r++)
        begin
            for (j = 0; j < tpm_pkg::CHARS_PER_WORD; j++)
                d[j*8 +: 8] = pat_bytes[r * tpm_pkg::CHARS_PER_WORD + j];
            write_reg(CHAR_REGS[r], d);
        end
        // indexes past the register list must be ignored
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
        cfg_we <= 1'b0;
        pat_len = clamp_len(plen_raw);
    endtask

    task automatic random_setting(input int phase);
        plen_t plen_raw;
        logic  m;
        int    k;
        int    r;
        m = 1'($urandom_range(0, 1));
        unique case (phase)
            0: plen_raw = '0;
            1:
            begin
                plen_raw = plen_t'(63);
                m        = tpm_pkg::MODE_WORD;
            end
            2:
            begin
                plen_raw = plen_t'(32);
                m        = tpm_pkg::MODE_LINE;
            end
            3: plen_raw = plen_t'(1);
            default:
            begin
                r = $urandom_range(0, 99);
                if (r < 70) plen_raw = plen_t'($urandom_range(1, 6));
                else if (r < 85) plen_raw = plen_t'($urandom_range(7, 20));
                else plen_raw = plen_t'($urandom_range(21, 63));
            end
        endcase
        pat_len = clamp_len(plen_raw);
        for (k = 0; k < tpm_pkg::PATTERN_MAX_DEF; k++) pat_bytes[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < pat_len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80) pat_bytes[k] = 8'("a" + $urandom_range(0, 3));
            else if (r < 97) pat_bytes[k] = word_char();
            else pat_bytes[k] = tpm_pkg::CHAR_SP;
        end
        program_matcher(m, plen_raw);
    endtask

    // pattern-shaped word: exact, near misses and one-character insertions
    task automatic emit_word();
        logic [7:0]  w [$];
        word_shape_t shape;
        int          k;
        for (k = 0; k < pat_len; k++) w.push_back(pat_bytes[k]);
        shape = word_shape_t'($urandom_range(0, 6));
        unique case (shape)
            SHAPE_INSERT:  w.insert($urandom_range(0, w.size()), word_char());
            SHAPE_WRAP:
            begin
                repeat ($urandom_range(0, 2)) w.push_front(word_char());
                repeat ($urandom_range(0, 2)) w.push_back(word_char());
            end
            SHAPE_DROP:    if (w.size() > 1) w.delete($urandom_range(0, w.size() - 1));
            SHAPE_SWAP:    w[$urandom_range(0, w.size() - 1)] = word_char();
            SHAPE_INSERT2: repeat (2) w.insert($urandom_range(0, w.size()), word_char());
            SHAPE_SCRAMBLE:
            begin
                w.delete();
                repeat ($urandom_range(1, pat_len + 2)) w.push_back(word_char());
            end
            default: ;
        endcase
        for (k = 0; k < w.size(); k++) send_text(w[k], 1'b0);
    endtask

    task automatic emit_line();
        logic [7:0] b;
        int         n;
        int         k;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == tpm_pkg::CHAR_NL) b = tpm_pkg::CHAR_TAB;
                send_text(b, 1'b0);
            end
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
            begin
                if (k > 0 || $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_text($urandom_range(0, 1) ? tpm_pkg::CHAR_SP : tpm_pkg::CHAR_TAB,
                                  1'b0);
                emit_word();
            end
            if ($urandom_range(0, 3) == 0) send_text(tpm_pkg::CHAR_SP, 1'b0);
        end
        if (!line_open || $urandom_range(0, 6) == 0) send_text(8'($urandom_range(0, 255)), 1'b1);
        else send_text(tpm_pkg::CHAR_NL, 1'b0);
        // end of text with nothing pending
        if ($urandom_range(0, 19) == 0) send_text(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 9) == 0) wait_idle();
    endtask

    initial
    begin
        int stall;
        report_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        int phase;
        int goal;
        int k;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= tpm_pkg::CFG_MODE;
        cfg_data            <= '0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        no_idle    = 1'b0;
        line_open  = 1'b0;
        items_sent = 0;
        for (k = 0; k < tpm_pkg::PATTERN_MAX_DEF; k++) pat_bytes[k] = 8'h00;
        pat_len = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: line mode, one-byte pattern of 0x00
        send_text("a", 1'b0);
        send_text(8'h00, 1'b0);
        send_text(tpm_pkg::CHAR_SP, 1'b0);
        send_text("b", 1'b0);
        send_text(tpm_pkg::CHAR_NL, 1'b0);
        send_text(8'h5A, 1'b1);

        // word mode: exact word and one-character insertions
        pat_bytes[0] = "c";
        pat_bytes[1] = "a";
        pat_bytes[2] = "t";
        program_matcher(tpm_pkg::MODE_WORD, plen_t'(3));
        send_string("cat\tcart cast");
        send_text(tpm_pkg::CHAR_NL, 1'b1);

        // mode switched while a word is still open
        send_string("cat");
        program_matcher(tpm_pkg::MODE_LINE, plen_t'(3));
        send_string(" x\n");

        // separator inside the pattern never matches
        pat_bytes[0] = "a";
        pat_bytes[1] = tpm_pkg::CHAR_SP;
        program_matcher(tpm_pkg::MODE_LINE, plen_t'(2));
        send_string("a a\n");

        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal)
        begin
            random_setting(phase);
            phase++;
            no_idle = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(2, 8)) emit_line();
            no_idle = 1'b0;
        end

        // empty line halts all reports
        pat_bytes[0] = "a";
        pat_bytes[1] = "b";
        program_matcher(tpm_pkg::MODE_WORD, plen_t'(2));
        send_string("ab ab\nab\n\n");
        send_text(8'h00, 1'b1);
        send_string("xab\n");

        wait_idle();
        repeat (5) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_text_word_pattern_matcher: PASS");
        else
            $display("tb_text_word_pattern_matcher: FAIL");
        $finish;
    end

endmodule
